// ----- rtl/gga_pkg.sv -----
// Shared constants, types and codes for the greedy graph aggregation core.
package gga_pkg;

  // Graph size and derived widths
  localparam int MAX_VERTICES = 1024;
  localparam int VX_W = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [VX_W-1:0] VX_LAST = VX_W'(MAX_VERTICES - 1);

  // Field widths of the words on the ports
  localparam int NB_W   = 10;
  localparam int ID_W   = 11;
  localparam int KIND_W = 2;

  // Aggregate counter saturates here
  localparam logic [ID_W-1:0] AGG_LIMIT = '1;

  // Result queue depth
  localparam int RES_DEPTH = 4;
  localparam int RES_PW    = $clog2(RES_DEPTH);
  localparam int RES_CW    = RES_PW + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_JOINED   = 2'd0,
    KIND_ROOT     = 2'd1,
    KIND_ISOLATED = 2'd2
  } kind_t;

  typedef struct packed {
    logic [NB_W-1:0] vertex;
    kind_t           kind;
    logic [ID_W-1:0] aggregate_id;
    logic [ID_W-1:0] aggregate_count;
    logic            last;
  } result_t;

  // One marker store write: enable, entry, aggregate id
  typedef struct packed {
    logic            en;
    logic [VX_W-1:0] addr;
    logic [ID_W-1:0] data;
  } mark_wr_t;

endpackage

// ----- rtl/gga_marker_ram.sv -----
// Marker store: one write port, two registered read ports.
module gga_marker_ram #(
  parameter int AW    = 10,
  parameter int DW    = 11,
  parameter int DEPTH = 1024
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_a_addr,
  output logic [DW-1:0] rd_a_data,
  input  logic [AW-1:0] rd_b_addr,
  output logic [DW-1:0] rd_b_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write, then read with old data on a same-edge collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// ----- rtl/gga_res_fifo.sv -----
// Small result queue between the marker pipeline and the output channel.
module gga_res_fifo import gga_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  result_t           push_word,
  output logic              valid,
  input  logic              ready,
  output result_t           word,
  output logic [RES_CW-1:0] count
);

  result_t           slots [RES_DEPTH];
  logic [RES_PW-1:0] wr_ptr;
  logic [RES_PW-1:0] rd_ptr;
  logic              pop;

  assign valid = (count != '0);
  assign pop   = valid && ready;
  assign word  = slots[rd_ptr];

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + RES_PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PW'(1);
      end
      if (push && !pop) begin
        count <= count + RES_CW'(1);
      end else if (pop && !push) begin
        count <= count - RES_CW'(1);
      end
    end
  end

endmodule

// ----- rtl/greedy_graph_aggregation_core.sv -----
// A row's result word is offered through the update stage registers and the result queue.
// Throughput: one entry word per cycle while the result queue has space; entry words are
// held when a row may open a new aggregate while the previous root marker still waits for
// the single write port. Reset and every graph end start a clearing pass over all
// MAX_VERTICES (1024) entries of the marker store, during which no entry word is taken.
module greedy_graph_aggregation_core import gga_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [NB_W-1:0]   neighbor,
  input  logic              entry_valid,
  input  logic              row_has_remote,
  input  logic              last_of_row,
  input  logic              last_of_graph,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [NB_W-1:0]   vertex,
  output logic [KIND_W-1:0] kind,
  output logic [ID_W-1:0]   aggregate_id,
  output logic [ID_W-1:0]   aggregate_count,
  output logic              last
);

  // Front: vertex counter and clearing pass
  logic            item_fire;
  logic [VX_W-1:0] vx_cnt;
  logic [VX_W-1:0] nb_addr;
  logic            nb_ok;
  logic            clr_busy;
  logic [VX_W-1:0] clr_addr;

  // Update stage registers
  logic            s1_v;
  logic [VX_W-1:0] s1_vx;
  logic [VX_W-1:0] s1_nb;
  logic            s1_nb_ok;
  logic            s1_ev;
  logic            s1_conn;
  logic            s1_row_end;
  logic            s1_graph_end;

  // Row and graph state
  logic [ID_W-1:0] row_agg;
  logic [ID_W-1:0] agg_cnt;

  // Deferred root marker, last write, write port
  mark_wr_t pend;
  mark_wr_t lw;
  mark_wr_t wr;

  logic [ID_W-1:0] rd_v_raw;
  logic [ID_W-1:0] rd_nb_raw;
  logic [ID_W-1:0] mv_fwd;
  logic [ID_W-1:0] mb_fwd;
  logic [ID_W-1:0] cnt_inc;
  logic [ID_W-1:0] cnt_after;
  logic [ID_W-1:0] ra;
  logic [ID_W-1:0] mv_after;
  logic [ID_W-1:0] mb;
  logic            root;
  logic            claim;
  logic            flush;
  logic            pend_en_next;
  logic [ID_W-1:0] row_agg_after;
  logic            possible_root;
  logic            space;

  result_t           res;
  result_t           out_word;
  logic [RES_CW-1:0] fifo_count;

  assign item_fire = item_valid && item_ready;
  assign nb_ok     = (32'(neighbor) < MAX_VERTICES);
  assign nb_addr   = VX_W'(neighbor);

  gga_marker_ram #(
    .AW    (VX_W),
    .DW    (ID_W),
    .DEPTH (MAX_VERTICES)
  ) u_marker (
    .clk       (clk),
    .wr_en     (wr.en),
    .wr_addr   (wr.addr),
    .wr_data   (wr.data),
    .rd_a_addr (vx_cnt),
    .rd_a_data (rd_v_raw),
    .rd_b_addr (nb_addr),
    .rd_b_data (rd_nb_raw)
  );

  // Forward the pending root and the write of the read edge
  always_comb begin
    if (pend.en && pend.addr == s1_vx) begin
      mv_fwd = pend.data;
    end else if (lw.en && lw.addr == s1_vx) begin
      mv_fwd = lw.data;
    end else begin
      mv_fwd = rd_v_raw;
    end
    if (pend.en && pend.addr == s1_nb) begin
      mb_fwd = pend.data;
    end else if (lw.en && lw.addr == s1_nb) begin
      mb_fwd = lw.data;
    end else begin
      mb_fwd = rd_nb_raw;
    end
  end

  // Root decision and neighbour claim
  always_comb begin
    root      = s1_v && (row_agg == '0) && s1_conn && (mv_fwd == '0);
    cnt_inc   = (agg_cnt < AGG_LIMIT) ? agg_cnt + ID_W'(1) : agg_cnt;
    cnt_after = root ? cnt_inc : agg_cnt;
    ra        = root ? cnt_inc : row_agg;
    mv_after  = root ? cnt_inc : mv_fwd;
    mb        = (s1_nb == s1_vx) ? mv_after : mb_fwd;
    claim     = s1_v && s1_ev && s1_nb_ok && (ra != '0) && (mb == '0);
    flush     = pend.en && !claim;
  end

  // Write port: claim first, then deferred root, then clearing
  always_comb begin
    if (claim) begin
      wr = '{en: 1'b1, addr: s1_nb, data: ra};
    end else if (flush) begin
      wr = pend;
    end else if (clr_busy && !s1_v) begin
      wr = '{en: 1'b1, addr: clr_addr, data: '0};
    end else begin
      wr = '{en: 1'b0, addr: s1_nb, data: ra};
    end
  end

  // Pending root occupancy after this edge
  always_comb begin
    if (s1_v && s1_row_end && s1_graph_end) begin
      pend_en_next = 1'b0;
    end else if (root) begin
      pend_en_next = 1'b1;
    end else if (flush) begin
      pend_en_next = 1'b0;
    end else begin
      pend_en_next = pend.en;
    end
  end

  // Hold entries that may open a root while the port is still owed a marker
  always_comb begin
    if (s1_v) begin
      row_agg_after = s1_row_end ? '0 : ra;
    end else begin
      row_agg_after = row_agg;
    end
    possible_root = (entry_valid || row_has_remote) && (row_agg_after == '0);
    space         = (32'(fifo_count) + 32'(s1_v)) < RES_DEPTH;
    item_ready    = !clr_busy && space && !(possible_root && pend_en_next);
  end

  // Result word of a row end
  always_comb begin
    res.vertex          = NB_W'(s1_vx);
    res.aggregate_count = cnt_after;
    res.last            = s1_graph_end;
    if (ra != '0) begin
      res.kind         = KIND_ROOT;
      res.aggregate_id = ra;
    end else if (mv_after != '0) begin
      res.kind         = KIND_JOINED;
      res.aggregate_id = mv_after;
    end else begin
      res.kind         = KIND_ISOLATED;
      res.aggregate_id = '0;
    end
  end

  // Front counters and clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      vx_cnt   <= '0;
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (item_fire && last_of_row) begin
      if (last_of_graph) begin
        vx_cnt   <= '0;
        clr_busy <= 1'b1;
        clr_addr <= '0;
      end else begin
        vx_cnt <= (vx_cnt == VX_LAST) ? '0 : vx_cnt + VX_W'(1);
      end
    end else if (clr_busy && !s1_v) begin
      clr_addr <= clr_addr + VX_W'(1);
      if (clr_addr == VX_LAST) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Capture the accepted word for the update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= item_fire;
    end
    if (item_fire) begin
      s1_vx        <= vx_cnt;
      s1_nb        <= nb_addr;
      s1_nb_ok     <= nb_ok;
      s1_ev        <= entry_valid;
      s1_conn      <= entry_valid || row_has_remote;
      s1_row_end   <= last_of_row;
      s1_graph_end <= last_of_graph;
    end
  end

  // Row aggregate and aggregate counter
  always_ff @(posedge clk) begin
    if (rst) begin
      row_agg <= '0;
      agg_cnt <= '0;
    end else if (s1_v) begin
      if (s1_row_end && s1_graph_end) begin
        row_agg <= '0;
        agg_cnt <= '0;
      end else begin
        row_agg <= s1_row_end ? '0 : ra;
        agg_cnt <= cnt_after;
      end
    end
  end

  // Deferred root marker and last write record
  always_ff @(posedge clk) begin
    if (rst) begin
      pend.en <= 1'b0;
      lw.en   <= 1'b0;
    end else begin
      pend.en <= pend_en_next;
      lw.en   <= wr.en;
    end
    if (root) begin
      pend.addr <= s1_vx;
      pend.data <= cnt_inc;
    end
    lw.addr <= wr.addr;
    lw.data <= wr.data;
  end

  gga_res_fifo u_res (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_v && s1_row_end),
    .push_word (res),
    .valid     (result_valid),
    .ready     (result_ready),
    .word      (out_word),
    .count     (fifo_count)
  );

  assign vertex          = out_word.vertex;
  assign kind            = out_word.kind;
  assign aggregate_id    = out_word.aggregate_id;
  assign aggregate_count = out_word.aggregate_count;
  assign last            = out_word.last;

endmodule

// ----- sim/greedy_graph_aggregation_core_test.sv -----
// Self-checking testbench for the greedy graph aggregation core: directed table, then random graphs.
module greedy_graph_aggregation_core_test
  import gga_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ENTRIES = 60;
  localparam int DRAIN_CYCLES = 16;
  localparam int WRAP_ROWS = MAX_VERTICES + 6;

  // One row of the directed table; want is only used where checked is set
  typedef struct packed {
    logic [NB_W-1:0] nb;
    logic            ev;
    logic            rem;
    logic            lor;
    logic            log;
    logic            checked;
    result_t         want;
  } dir_row_t;

  localparam int DIR_N = 18;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  logic [NB_W-1:0] neighbor;
  logic entry_valid;
  logic row_has_remote;
  logic last_of_row;
  logic last_of_graph;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [NB_W-1:0] vertex;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0] aggregate_id;
  logic [ID_W-1:0] aggregate_count;
  logic last;

  // Predictor state: aggregate marks per vertex, row and aggregate counters
  logic [ID_W-1:0] marks [MAX_VERTICES];
  logic [VX_W-1:0] row_vertex;
  logic [ID_W-1:0] aggregates_made;
  logic [ID_W-1:0] row_root_id;

  result_t pending_assignments [$];
  int fail_count = 0;
  int entries_sent = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;

  dir_row_t dir_tab [DIR_N] = '{
    // isolated vertex 0
    '{10'd0,    1'b0, 1'b0, 1'b1, 1'b0, 1'b1, '{10'd0, KIND_ISOLATED, 11'd0, 11'd0, 1'b0}},
    // vertex 1 opens aggregate 1, claims 2 and 1023
    '{10'd2,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{10'd1023, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, '{10'd1, KIND_ROOT, 11'd1, 11'd1, 1'b0}},
    // remote-only row on a claimed vertex joins
    '{10'd0,    1'b0, 1'b1, 1'b1, 1'b0, 1'b1, '{10'd2, KIND_JOINED, 11'd1, 11'd1, 1'b0}},
    // mixed marks: root taken at first connected word
    '{10'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{10'd4,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{10'd5,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{10'd5,    1'b1, 1'b0, 1'b1, 1'b0, 1'b1, '{10'd3, KIND_ROOT, 11'd2, 11'd2, 1'b0}},
    // claimed vertex with a neighbour claims nothing
    '{10'd6,    1'b1, 1'b0, 1'b1, 1'b0, 1'b1, '{10'd4, KIND_JOINED, 11'd2, 11'd2, 1'b0}},
    // graph end flag without row end is ignored
    '{10'd7,    1'b1, 1'b0, 1'b0, 1'b1, 1'b0, '0},
    '{10'd0,    1'b0, 1'b0, 1'b1, 1'b0, 1'b1, '{10'd5, KIND_JOINED, 11'd2, 11'd2, 1'b0}},
    '{10'd1023, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, '{10'd6, KIND_ROOT, 11'd3, 11'd3, 1'b1}},
    // single-row graphs after the clear
    '{10'd1023, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{10'd0,    1'b0, 1'b0, 1'b1, 1'b1, 1'b1, '{10'd0, KIND_ROOT, 11'd1, 11'd1, 1'b1}},
    '{10'd0,    1'b0, 1'b0, 1'b1, 1'b1, 1'b1, '{10'd0, KIND_ISOLATED, 11'd0, 11'd0, 1'b1}},
    // self loop, then alternating neighbour bits
    '{10'd0,    1'b1, 1'b0, 1'b1, 1'b0, 1'b1, '{10'd0, KIND_ROOT, 11'd1, 11'd1, 1'b0}},
    '{10'd682,  1'b1, 1'b0, 1'b1, 1'b0, 1'b1, '{10'd1, KIND_ROOT, 11'd2, 11'd2, 1'b0}},
    '{10'd341,  1'b1, 1'b0, 1'b1, 1'b1, 1'b1, '{10'd2, KIND_ROOT, 11'd3, 11'd3, 1'b1}}
  };

  greedy_graph_aggregation_core dut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .neighbor        (neighbor),
    .entry_valid     (entry_valid),
    .row_has_remote  (row_has_remote),
    .last_of_row     (last_of_row),
    .last_of_graph   (last_of_graph),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .vertex          (vertex),
    .kind            (kind),
    .aggregate_id    (aggregate_id),
    .aggregate_count (aggregate_count),
    .last            (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles at %0t", cycles, $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Clear the graph state of the predictor
  task automatic clear_graph();
    foreach (marks[i]) marks[i] = '0;
    row_vertex = '0;
    aggregates_made = '0;
    row_root_id = '0;
  endtask

  // Advance the predictor by one entry word; got is set at a row end
  task automatic predict_assignment(input logic [NB_W-1:0] nb, input logic ev, input logic rem,
                                    input logic lor, input logic log,
                                    output bit got, output result_t res);
    logic [VX_W-1:0] v;
    v = row_vertex;
    got = 1'b0;
    res = '0;
    // open a new aggregate at the first connected word of an undecided row
    if (row_root_id == '0 && (ev || rem) && marks[v] == '0) begin
      if (aggregates_made != AGG_LIMIT) aggregates_made = aggregates_made + 1'b1;
      row_root_id = aggregates_made;
      marks[v] = row_root_id;
    end
    // claim an undecided neighbour for this row's aggregate
    if (ev && row_root_id != '0 && int'(nb) < MAX_VERTICES && marks[nb] == '0) begin
      marks[nb] = row_root_id;
    end
    if (lor) begin
      got = 1'b1;
      res.vertex = NB_W'(v);
      res.aggregate_count = aggregates_made;
      res.last = log;
      if (row_root_id != '0) begin
        res.kind = KIND_ROOT;
        res.aggregate_id = row_root_id;
      end else if (marks[v] != '0) begin
        res.kind = KIND_JOINED;
        res.aggregate_id = marks[v];
      end else begin
        res.kind = KIND_ISOLATED;
        res.aggregate_id = '0;
      end
      if (log) begin
        clear_graph();
      end else begin
        row_vertex = (row_vertex == VX_LAST) ? '0 : row_vertex + 1'b1;
        row_root_id = '0;
      end
    end
  endtask

  // Offer one entry word after a random gap, hold it until taken, then predict
  task automatic send_entry(input logic [NB_W-1:0] nb, input logic ev, input logic rem,
                            input logic lor, input logic log,
                            input logic checked, input result_t want);
    int gap;
    bit got;
    result_t res;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    neighbor <= nb;
    entry_valid <= ev;
    row_has_remote <= rem;
    last_of_row <= lor;
    last_of_graph <= log;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    entries_sent++;
    predict_assignment(nb, ev, rem, lor, log, got, res);
    if (got) pending_assignments.push_back(checked ? want : res);
  endtask

  // Stream one random graph; max_k bounds the entry words per row
  task automatic send_graph(input int rows, input int max_k);
    int style;
    int k;
    int span;
    logic rem;
    logic ev;
    logic lor;
    logic log;
    logic [NB_W-1:0] nb;
    span = (rows > MAX_VERTICES) ? MAX_VERTICES - 1 : rows - 1;
    for (int r = 0; r < rows; r++) begin
      style = $urandom_range(0, 99);
      k = (style < 25) ? 1 : $urandom_range(1, max_k);
      rem = ($urandom_range(0, 99) < 30);
      for (int e = 0; e < k; e++) begin
        if ($urandom_range(0, 4) == 0) nb = NB_W'($urandom_range(0, 1023));
        else nb = NB_W'($urandom_range(0, span));
        lor = (e == k - 1);
        if (lor) log = (r == rows - 1);
        else log = ($urandom_range(0, 19) == 0);
        if (style < 15) begin
          // isolated row
          send_entry(nb, 1'b0, 1'b0, lor, log, 1'b0, '0);
        end else if (style < 25) begin
          // remote connections only
          send_entry(nb, 1'b0, 1'b1, lor, log, 1'b0, '0);
        end else if (style < 90) begin
          send_entry(nb, 1'b1, rem, lor, log, 1'b0, '0);
        end else begin
          // broken row: entry and remote flags change word by word
          ev = 1'($urandom_range(0, 1));
          send_entry(nb, ev, 1'(($urandom_range(0, 1))), lor, log, 1'b0, '0);
        end
      end
    end
  endtask

  // Run random graphs until the phase has moved its share of words
  task automatic run_phase(input int s_idle, input int r_idle, input bit drain_often);
    int start;
    int n_graph;
    int rows;
    start = entries_sent;
    n_graph = 0;
    send_idle = s_idle;
    recv_idle = r_idle;
    while (entries_sent - start < PHASE_ENTRIES) begin
      rows = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 200) : $urandom_range(1, 48);
      send_graph(rows, 4);
      n_graph++;
      // hold the sender until every result is back
      if (drain_often && n_graph % 4 == 1) begin
        item_valid <= 1'b0;
        while (pending_assignments.size() != 0) @(posedge clk);
      end
    end
  endtask

  // Check each result word against the oldest expectation; stall at random
  always @(posedge clk) begin
    result_t w;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (pending_assignments.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, vertex %0d kind %0d id %0d count %0d last %0d",
                   $time, vertex, kind, aggregate_id, aggregate_count, last);
        end else begin
          w = pending_assignments.pop_front();
          if (vertex !== w.vertex) begin
            fail_count++;
            $display("%0t: vertex expected %0d actual %0d", $time, w.vertex, vertex);
          end
          if (kind !== w.kind) begin
            fail_count++;
            $display("%0t: kind expected %0d actual %0d", $time, w.kind, kind);
          end
          if (aggregate_id !== w.aggregate_id) begin
            fail_count++;
            $display("%0t: aggregate_id expected %0d actual %0d", $time, w.aggregate_id,
                     aggregate_id);
          end
          if (aggregate_count !== w.aggregate_count) begin
            fail_count++;
            $display("%0t: aggregate_count expected %0d actual %0d", $time,
                     w.aggregate_count, aggregate_count);
          end
          if (last !== w.last) begin
            fail_count++;
            $display("%0t: last expected %0d actual %0d", $time, w.last, last);
          end
        end
      end
      result_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Reset, directed table, three random phases, wrap-around graph, drain
  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    neighbor <= '0;
    entry_valid <= 1'b0;
    row_has_remote <= 1'b0;
    last_of_row <= 1'b0;
    last_of_graph <= 1'b0;
    clear_graph();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_idle = 29;
    recv_idle = 77;
    for (int i = 0; i < DIR_N; i++) begin
      send_entry(dir_tab[i].nb, dir_tab[i].ev, dir_tab[i].rem, dir_tab[i].lor,
                 dir_tab[i].log, dir_tab[i].checked, dir_tab[i].want);
    end

    run_phase(29, 77, 1'b0);
    run_phase(77, 29, 1'b1);
    run_phase(0, 0, 1'b0);

    // more rows than vertices: the row counter wraps without clearing marks
    item_valid <= 1'b0;
    while (pending_assignments.size() != 0) @(posedge clk);
    send_graph(WRAP_ROWS, 1);

    item_valid <= 1'b0;
    while (pending_assignments.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
